// File: rtl/emi_pkg.sv
// ----------------------------------------------------------------------------
// emi_pkg: shared types and constants for the modular inverse block
// Operand widths, result status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package emi_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int COEF_WIDTH    = OPERAND_WIDTH + 1;
	localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

	typedef logic [OPERAND_WIDTH-1:0] operand_t;
	typedef logic [COEF_WIDTH-1:0]    coef_t;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_ORDER       = 2'd1,
		STAT_NOT_COPRIME = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_UPD,
		ST_FIX_SIGN,
		ST_FIX_RED,
		ST_FIX_INV,
		ST_DONE
	} state_t;

endpackage

// File: rtl/emi_in_if.sv
// ----------------------------------------------------------------------------
// emi_in_if: operand channel
// Valid/ready channel carrying value_a and modulus_b.
// ----------------------------------------------------------------------------
interface emi_in_if import emi_pkg::*;;
	logic     valid;
	logic     ready;
	operand_t value_a;
	operand_t modulus_b;

	modport source (output valid, output value_a, output modulus_b, input ready);
	modport sink   (input valid, input value_a, input modulus_b, output ready);
endinterface

// File: rtl/emi_out_if.sv
// ----------------------------------------------------------------------------
// emi_out_if: result channel
// Valid/ready channel carrying gcd, Bezout coefficients, inverse and status.
// ----------------------------------------------------------------------------
interface emi_out_if import emi_pkg::*;;
	logic     valid;
	logic     ready;
	operand_t gcd_value;
	coef_t    coef_a;
	coef_t    coef_b;
	operand_t inverse_value;
	status_t  status_code;

	modport source (output valid, output gcd_value, output coef_a, output coef_b,
		output inverse_value, output status_code, input ready);
	modport sink   (input valid, input gcd_value, input coef_a, input coef_b,
		input inverse_value, input status_code, output ready);
endinterface

// File: rtl/extended_euclid_mod_inverse.sv
// ----------------------------------------------------------------------------
// extended_euclid_mod_inverse: extended Euclid gcd and modular inverse
// Runs the extended Euclidean algorithm on a shared restoring divider and
// returns gcd, signed Bezout coefficients and the inverse reduced mod b.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   value_a, modulus_b
//  out_ch   out  valid/ready   gcd_value, coef_a, coef_b, inverse_value,
//                              status_code
//
// Flow: one transaction in flight. A rejected operand pair (a > b) shows
// its result the cycle after acceptance. Otherwise each Euclid step runs
// the shared restoring divider, one quotient bit per cycle, and then the
// update state; FIX_SIGN, FIX_RED and FIX_INV then reduce the inverse.
// Reset: arst_n clears the sequencer; no clearing pass is needed.
// Stalls: in_ch.ready is high only when idle; the result holds in its
// output register until out_ch takes it.
// ----------------------------------------------------------------------------
module extended_euclid_mod_inverse import emi_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	emi_in_if.sink   in_ch,
	emi_out_if.source out_ch
);

	localparam int W = OPERAND_WIDTH;
	localparam int C = COEF_WIDTH;

	state_t state_q, state_d;

	// running remainders and coefficients
	operand_t rp_q, rc_q, b_q;
	coef_t    xp_q, xc_q, yp_q, yc_q;

	// divider: partial remainder, dividend shift, q*x and q*y accumulators
	operand_t             r_q, dq_q;
	coef_t                accx_q, accy_q;
	logic [CNT_WIDTH-1:0] cnt_q;

	// inverse fixup
	logic  neg_q;
	coef_t mag_q;

	// result register
	operand_t gcd_q, inv_q;
	coef_t    coefa_q, coefb_q;
	status_t  stat_q;

	logic           in_fire, out_fire;
	logic [W:0]     trial, diff;
	logic           ge;
	logic           last_bit;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;

	// shared subtract/compare of the restoring divider
	assign trial    = {r_q, dq_q[W-1]};
	assign diff     = trial - {1'b0, rc_q};
	assign ge       = !diff[W];
	assign last_bit = (cnt_q == CNT_WIDTH'(W-1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_ch.value_a > in_ch.modulus_b)
						state_d = ST_DONE;
					else if (in_ch.value_a == '0)
						state_d = ST_FIX_SIGN;
					else
						state_d = ST_DIV;
				end
			end
			ST_DIV:      if (last_bit) state_d = ST_UPD;
			ST_UPD:      state_d = (r_q == '0) ? ST_FIX_SIGN : ST_DIV;
			ST_FIX_SIGN: state_d = ST_FIX_RED;
			ST_FIX_RED:  state_d = ST_FIX_INV;
			ST_FIX_INV:  state_d = ST_DONE;
			ST_DONE:     if (out_fire) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ch.ready  = (state_q == ST_IDLE);
		out_ch.valid = (state_q == ST_DONE);
	end

	assign out_ch.gcd_value     = gcd_q;
	assign out_ch.coef_a        = coefa_q;
	assign out_ch.coef_b        = coefb_q;
	assign out_ch.inverse_value = inv_q;
	assign out_ch.status_code   = stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rp_q   <= in_ch.modulus_b;
				rc_q   <= in_ch.value_a;
				b_q    <= in_ch.modulus_b;
				xp_q   <= '0;
				xc_q   <= C'(1);
				yp_q   <= C'(1);
				yc_q   <= '0;
				r_q    <= '0;
				dq_q   <= in_ch.modulus_b;
				accx_q <= '0;
				accy_q <= '0;
				cnt_q  <= '0;
				// rejected pair: result is all zeros with order status
				gcd_q   <= '0;
				coefa_q <= '0;
				coefb_q <= '0;
				inv_q   <= '0;
				stat_q  <= STAT_ORDER;
			end
			ST_DIV: begin
				r_q    <= ge ? diff[W-1:0] : trial[W-1:0];
				dq_q   <= {dq_q[W-2:0], 1'b0};
				accx_q <= {accx_q[C-2:0], 1'b0} + (ge ? xc_q : '0);
				accy_q <= {accy_q[C-2:0], 1'b0} + (ge ? yc_q : '0);
				cnt_q  <= cnt_q + CNT_WIDTH'(1);
			end
			ST_UPD: begin
				// new coefficients: prev - q*cur, exact mod 2^C
				rp_q   <= rc_q;
				rc_q   <= r_q;
				xp_q   <= xc_q;
				xc_q   <= xp_q - accx_q;
				yp_q   <= yc_q;
				yc_q   <= yp_q - accy_q;
				r_q    <= '0;
				dq_q   <= rc_q;
				accx_q <= '0;
				accy_q <= '0;
				cnt_q  <= '0;
			end
			ST_FIX_SIGN: begin
				neg_q <= xp_q[C-1];
				mag_q <= xp_q[C-1] ? (C'(0) - xp_q) : xp_q;
			end
			ST_FIX_RED: begin
				if (mag_q >= {1'b0, b_q})
					mag_q <= mag_q - {1'b0, b_q};
			end
			ST_FIX_INV: begin
				gcd_q   <= rp_q;
				coefa_q <= xp_q;
				coefb_q <= yp_q;
				if (rp_q == W'(1)) begin
					stat_q <= STAT_OK;
					if (!neg_q)
						inv_q <= mag_q[W-1:0];
					else if (mag_q == '0)
						inv_q <= '0;
					else
						inv_q <= b_q - mag_q[W-1:0];
				end else begin
					stat_q <= STAT_NOT_COPRIME;
					inv_q  <= '0;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	// never accepting while a result is pending
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("input ready while result pending");

	// a rejected pair answers on the next cycle
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (in_ch.value_a > in_ch.modulus_b)) |=>
		(out_ch.valid && (out_ch.status_code == STAT_ORDER)))
		else $error("rejected pair not reported");

	// divider never runs on a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rc_q != '0))
		else $error("division by zero remainder");

	// ok status only with unit gcd
	a_ok_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.status_code == STAT_OK)) |->
		(out_ch.gcd_value == W'(1)))
		else $error("ok status with gcd not one");

	// error results carry a zero inverse
	a_err_inv: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.status_code != STAT_OK)) |->
		(out_ch.inverse_value == '0))
		else $error("nonzero inverse on error");
`endif

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for extended_euclid_mod_inverse
// Sends operand pairs over the valid/ready input channel and computes the
// expected gcd, Bezout coefficients, inverse and status for each one. Every
// result transaction is compared field by field against the oldest expected
// entry. Directed corner cases come first, then random traffic with random
// input gaps and result back-pressure, apart from one back-to-back stretch.
// ----------------------------------------------------------------------------
module testbench import emi_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Worst case per pair is the longest Euclid chain plus idle time on both
	// sides. The limit allows several times the slowest legal run.
	localparam int CYCLE_LIMIT  = 2_000_000;
	// Quiet time after the last result, long enough for a stray one to show up
	localparam int DRAIN_CYCLES = 1600;

	typedef struct {
		operand_t value_a;
		operand_t modulus_b;
		operand_t gcd_value;
		coef_t    coef_a;
		coef_t    coef_b;
		operand_t inverse_value;
		status_t  status_code;
	} inverse_result_t;

	logic clk = 1'b0;
	logic arst_n;

	emi_in_if  in_ch();
	emi_out_if out_ch();

	extended_euclid_mod_inverse u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Results still owed by the block, oldest first
	inverse_result_t pending_results[$];
	int unsigned     error_count = 0;
	int unsigned     cycle_count = 0;
	// Set during stretches where neither side inserts gaps or stalls
	bit              no_idle     = 1'b0;
	int              stall_left  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap length for either side: mostly none or short, now and then long
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(99);
		if (no_idle || roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(3, 1);
		return $urandom_range(60, 20);
	endfunction

	// Expected result of one operand pair. Coefficients are run in 64-bit
	// two's complement; their true magnitude never exceeds the modulus, so
	// the low COEF_WIDTH bits carry the signed value.
	function automatic inverse_result_t predict_inverse(operand_t a, operand_t b);
		inverse_result_t res;
		logic [63:0] rem_hi, rem_lo, xa_hi, xa_lo, yb_hi, yb_lo;
		logic [63:0] quot, rem_nx, xa_nx, yb_nx, mag, inv, b64;
		res.value_a   = a;
		res.modulus_b = b;
		if (a > b) begin
			// order rejected: all numeric fields cleared
			res.gcd_value     = '0;
			res.coef_a        = '0;
			res.coef_b        = '0;
			res.inverse_value = '0;
			res.status_code   = STAT_ORDER;
			return res;
		end
		b64    = {32'd0, b};
		rem_hi = b64;
		rem_lo = {32'd0, a};
		yb_hi  = 64'd1;
		yb_lo  = 64'd0;
		xa_hi  = 64'd0;
		xa_lo  = 64'd1;
		while (rem_lo != 64'd0) begin
			quot   = rem_hi / rem_lo;
			rem_nx = rem_hi % rem_lo;
			xa_nx  = xa_hi - quot * xa_lo;
			yb_nx  = yb_hi - quot * yb_lo;
			rem_hi = rem_lo;
			rem_lo = rem_nx;
			xa_hi  = xa_lo;
			xa_lo  = xa_nx;
			yb_hi  = yb_lo;
			yb_lo  = yb_nx;
		end
		if (rem_hi == 64'd1) begin
			// coprime, so b >= 1; fold a negative coefficient into 0..b-1
			res.status_code = STAT_OK;
			if (xa_hi[63]) begin
				mag = (64'd0 - xa_hi) % b64;
				inv = (mag == 64'd0) ? 64'd0 : (b64 - mag);
			end else begin
				inv = xa_hi % b64;
			end
		end else begin
			res.status_code = STAT_NOT_COPRIME;
			inv = 64'd0;
		end
		res.gcd_value     = rem_hi[OPERAND_WIDTH-1:0];
		res.coef_a        = xa_hi[COEF_WIDTH-1:0];
		res.coef_b        = yb_hi[COEF_WIDTH-1:0];
		res.inverse_value = inv[OPERAND_WIDTH-1:0];
		return res;
	endfunction

	function automatic void check_field(string name, inverse_result_t exp_res,
			logic [63:0] exp_val, logic [63:0] act_val);
		if (exp_val !== act_val) begin
			error_count++;
			$display("%0t: %s mismatch for a=%h b=%h: expected %h, actual %h",
				$time, name, exp_res.value_a, exp_res.modulus_b, exp_val, act_val);
		end
	endfunction

	// Result side: compare every accepted result transaction with the oldest
	// expected entry.
	always @(posedge clk) begin
		inverse_result_t exp_res;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result: expected none, actual gcd=%h status=%0d",
					$time, out_ch.gcd_value, out_ch.status_code);
			end else begin
				exp_res = pending_results.pop_front();
				check_field("gcd_value", exp_res, exp_res.gcd_value, out_ch.gcd_value);
				check_field("coef_a", exp_res, exp_res.coef_a, out_ch.coef_a);
				check_field("coef_b", exp_res, exp_res.coef_b, out_ch.coef_b);
				check_field("inverse_value", exp_res, exp_res.inverse_value,
					out_ch.inverse_value);
				check_field("status_code", exp_res, exp_res.status_code,
					out_ch.status_code);
			end
		end
	end

	// Result back-pressure: random stalls, none while no_idle is set
	always @(negedge clk) begin
		int n;
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			n = idle_len();
			if (n > 0) begin
				out_ch.ready <= 1'b0;
				stall_left   <= n - 1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Sends one operand pair. Entered and left at a falling edge with valid
	// still high, so a following call can keep it high without a glitch.
	task automatic send_operands(input operand_t a, input operand_t b);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.value_a   <= a;
		in_ch.modulus_b <= b;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pending_results.push_back(predict_inverse(a, b));
		@(negedge clk);
	endtask

	// Random a in 0..b
	function automatic operand_t pick_below(operand_t b);
		longint unsigned span;
		span = longint'(b) + 1;
		return operand_t'(({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % span);
	endfunction

	// Well-formed pair (a <= b) with a spread of modulus sizes
	task automatic send_well_formed();
		operand_t a, b;
		int       roll;
		roll = $urandom_range(99);
		if (roll < 50)
			b = $urandom;
		else if (roll < 75)
			b = $urandom & ((32'd1 << $urandom_range(31, 1)) - 1);
		else
			b = $urandom_range(255, 1);
		roll = $urandom_range(99);
		if (roll < 85)
			a = pick_below(b);
		else if (roll < 90)
			a = b;
		else if (roll < 95)
			a = (b == '0) ? '0 : b - 1;
		else
			a = roll[0];
		if (a > b)
			a = b;
		send_operands(a, b);
	endtask

	// Corner cases called out for the block
	task automatic test_special_cases();
		send_operands(32'd0, 32'd0);                 // both zero
		send_operands(32'd0, 32'd1);                 // modulus one, a zero
		send_operands(32'd1, 32'd1);                 // modulus one
		send_operands(32'd0, 32'd7);                 // a zero, no inverse
		send_operands(32'd5, 32'd3);                 // order rejected
		send_operands(32'hffff_ffff, 32'd0);         // rejected, widest a
		send_operands(32'd1, 32'd0);                 // rejected, zero modulus
		send_operands(32'd12, 32'd18);               // not coprime
		send_operands(32'd9, 32'd9);                 // a equal to b
		send_operands(32'd3, 32'd7);                 // small coprime
		send_operands(32'd4, 32'd7);                 // positive coefficient
	endtask

	// Field extremes and the longest Euclid chain
	task automatic test_extremes();
		send_operands(32'hffff_ffff, 32'hffff_ffff); // gcd is the maximum
		send_operands(32'hffff_fffe, 32'hffff_ffff);
		send_operands(32'd1, 32'hffff_ffff);
		send_operands(32'd0, 32'hffff_ffff);
		send_operands(32'h8000_0000, 32'hffff_ffff);
		send_operands(32'h7fff_ffff, 32'h8000_0000);
		send_operands(32'h5555_5555, 32'haaaa_aaab);
		// consecutive Fibonacci numbers: most division steps at this width
		send_operands(32'd1836311903, 32'd2971215073);
		send_operands(32'd1134903170, 32'd1836311903);
		send_operands(32'hffff_fffe, 32'hffff_fffe);
		send_operands(32'hffff_ffff, 32'hffff_fffe); // rejected, near max
	endtask

	task automatic test_random_well_formed(input int count);
		repeat (count) send_well_formed();
	endtask

	// Mostly out-of-order pairs, with some unrestricted ones mixed in
	task automatic test_random_noise(input int count);
		operand_t a, b;
		repeat (count) begin
			a = $urandom;
			b = $urandom;
			if ($urandom_range(3) != 0) begin
				if (a == b)
					a = ~b;
				if (a < b) begin
					a = a ^ b;
					b = a ^ b;
					a = a ^ b;
				end
			end
			send_operands(a, b);
		end
	endtask

	// No gaps and no stalls: results and new operands meet edge to edge
	task automatic test_back_to_back(input int count);
		no_idle = 1'b1;
		repeat (count) send_well_formed();
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.value_a   = '0;
		in_ch.modulus_b = '0;
		out_ch.ready    = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_special_cases();
		test_extremes();
		test_random_well_formed(140);
		test_back_to_back(40);
		test_random_noise(40);
		test_random_well_formed(70);

		in_ch.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
